>>> rtl/wts_pkg.sv
// shared types, codes and tables for the three-voice wavetable synth
// no dependencies; imported by every module of the block
package wts_pkg;

   localparam int VOICE_COUNT      = 3;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int VOICE_IDX_W      = $clog2(VOICE_COUNT);
   localparam int PHASE_W          = 9;
   localparam int DUR_W            = 8;
   localparam int SAMPLE_W         = 8;
   localparam int SUM_W            = 10;
   localparam int COUNT_W          = 2;
   localparam int PRESCALE_W       = 3;

   // reciprocal of three for sums up to 3 * 255
   localparam int           DIV3_SHIFT = 11;
   localparam logic [SUM_W-1:0] DIV3_RECIP = 10'd683;

   typedef enum logic [2:0] {
      ACT_SAMPLE_TICK = 3'd0,
      ACT_SEQ_STEP    = 3'd1,
      ACT_NOTE_ON     = 3'd2,
      ACT_SET_WAVE    = 3'd3,
      ACT_STOP_VOICE  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_TRIANGLE = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_SAWTOOTH = 2'd3
   } wave_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VOICE,
      ST_MIX
   } state_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [PHASE_W-1:0] step;
      wave_type           wave;
   } voice_op_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } mix_acc_type;

   localparam logic [6:0] QUARTER_SINE [0:64] = '{
        7'd0,   7'd3,   7'd6,   7'd9,  7'd12,  7'd16,  7'd19,  7'd22,  7'd25,  7'd28,
       7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,  7'd49,  7'd51,  7'd54,  7'd57,
       7'd60,  7'd63,  7'd65,  7'd68,  7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,
       7'd85,  7'd88,  7'd90,  7'd92,  7'd94,  7'd96,  7'd98, 7'd100, 7'd102, 7'd104,
      7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116, 7'd117, 7'd118,
      7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126,
      7'd126, 7'd127, 7'd127, 7'd127, 7'd127
   };

   // full-scale sine from an 8-bit table index, folded onto the quarter wave
   function automatic logic [SAMPLE_W-1:0] sine_value(input logic [7:0] idx);
      logic [6:0] k;
      logic [6:0] q;
      k = idx[6:0];
      if (k > 7'd64) begin
         k = 7'd0 - k;
      end
      q = QUARTER_SINE[k];
      if (!idx[7]) begin
         sine_value = 8'd128 + {1'b0, q};
      end else begin
         sine_value = 8'd127 - {1'b0, q};
      end
   endfunction

endpackage

>>> rtl/wts_voice_unit.sv
// shared voice unit: phase advance and waveform shaping for one voice
// depends on wts_pkg
module wts_voice_unit (
   input  wts_pkg::voice_op_type                 op,
   output logic [wts_pkg::PHASE_W-1:0]           new_phase,
   output logic [wts_pkg::SAMPLE_W-1:0]          sample
);
   import wts_pkg::*;

   logic [SAMPLE_W-1:0] low_bits;

   assign new_phase = op.phase + op.step;
   assign low_bits  = new_phase[SAMPLE_W-1:0];

   always_comb begin
      case (op.wave)
         WAVE_SINE:     sample = sine_value(new_phase[PHASE_W-1:1]);
         WAVE_TRIANGLE: sample = new_phase[PHASE_W-1] ? ~low_bits : low_bits;
         WAVE_SQUARE:   sample = {SAMPLE_W{new_phase[PHASE_W-1]}};
         WAVE_SAWTOOTH: sample = new_phase[PHASE_W-1:1];
         default:       sample = '0;
      endcase
   end

endmodule

>>> rtl/wts_mix_divide.sv
// averaging stage: divides the accumulated voice sum by the voice count
// depends on wts_pkg
module wts_mix_divide (
   input  wts_pkg::mix_acc_type          acc,
   output logic [wts_pkg::SAMPLE_W-1:0]  average
);
   import wts_pkg::*;

   logic [2*SUM_W-1:0] third_prod;

   assign third_prod = acc.sum * DIV3_RECIP;

   always_comb begin
      case (acc.count)
         2'd1:    average = acc.sum[SAMPLE_W-1:0];
         2'd2:    average = acc.sum[SAMPLE_W:1];
         2'd3:    average = third_prod[DIV3_SHIFT+SAMPLE_W-1:DIV3_SHIFT];
         default: average = '0;
      endcase
   end

endmodule

>>> rtl/three_voice_wavetable_synth_top.sv
// Three-voice wavetable synth. One sample tick in eight generates a sample: a single
// shared voice unit advances and shapes the voices one per cycle, so the tick is
// accepted in the idle state, then passes through the voice state once per voice and
// then the mix state, which, when a voice sounds, waits further while an earlier
// result has not yet been taken. A result leaves only when at least one voice sounds;
// req_tready is low while a generating tick is being worked.
// depends on wts_pkg, wts_voice_unit and wts_mix_divide
module three_voice_wavetable_synth_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // phase_step[8:0], note_duration[16:9], voice_index[18:17], wave_select[20:19], zero fill
   input  logic [23:0] req_tdata,
   // action[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // duty[7:0], voices_sounding[9:8], zero fill
   output logic [15:0] rsp_tdata
);
   import wts_pkg::*;

   localparam logic [VOICE_IDX_W-1:0] LAST_VOICE = VOICE_IDX_W'(VOICE_COUNT - 1);

   logic [PHASE_W-1:0]     phase_ff     [VOICE_COUNT];
   logic [PHASE_W-1:0]     phase_in     [VOICE_COUNT];
   logic [PHASE_W-1:0]     step_ff      [VOICE_COUNT];
   logic [PHASE_W-1:0]     step_in      [VOICE_COUNT];
   wave_type               wave_ff      [VOICE_COUNT];
   wave_type               wave_in      [VOICE_COUNT];
   logic [DUR_W-1:0]       remaining_ff [VOICE_COUNT];
   logic [DUR_W-1:0]       remaining_in [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] busy_ff, busy_in;
   logic [PRESCALE_W-1:0]  prescale_ff, prescale_in;
   logic [VOICE_IDX_W-1:0] vidx_ff, vidx_in;
   mix_acc_type            acc_ff, acc_in;
   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    duty_ff, duty_in;
   logic [COUNT_W-1:0]     sounding_ff, sounding_in;

   action_type             action;
   logic [PHASE_W-1:0]     req_step;
   logic [DUR_W-1:0]       req_dur;
   logic [1:0]             req_voice;
   wave_type               req_wave;
   logic                   accept;
   logic                   out_free;
   logic [VOICE_IDX_W-1:0] note_voice;
   voice_op_type           unit_op;
   logic [PHASE_W-1:0]     unit_phase;
   logic [SAMPLE_W-1:0]    unit_sample;
   logic [SAMPLE_W-1:0]    average;

   assign action    = action_type'(req_tuser);
   assign req_step  = req_tdata[8:0];
   assign req_dur   = req_tdata[16:9];
   assign req_voice = req_tdata[18:17];
   assign req_wave  = wave_type'(req_tdata[20:19]);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, sounding_ff, duty_ff};

   assign unit_op.phase = phase_ff[vidx_ff];
   assign unit_op.step  = step_ff[vidx_ff];
   assign unit_op.wave  = wave_ff[vidx_ff];

   wts_voice_unit u_voice_unit (
      .op        (unit_op),
      .new_phase (unit_phase),
      .sample    (unit_sample)
   );

   wts_mix_divide u_mix_divide (
      .acc     (acc_ff),
      .average (average)
   );

   // lowest free voice, else the last one
   always_comb begin
      if (!busy_ff[0]) begin
         note_voice = VOICE_IDX_W'(0);
      end else if (!busy_ff[1]) begin
         note_voice = VOICE_IDX_W'(1);
      end else begin
         note_voice = LAST_VOICE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && action == ACT_SAMPLE_TICK && prescale_ff == '0) begin
               state_in = ST_VOICE;
            end
         end
         ST_VOICE: begin
            if (vidx_ff == LAST_VOICE) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            if (acc_ff.count == '0 || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // voice state and datapath
   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      wave_in      = wave_ff;
      remaining_in = remaining_ff;
      busy_in      = busy_ff;
      prescale_in  = prescale_ff;
      vidx_in      = vidx_ff;
      acc_in       = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (action)
                  ACT_SAMPLE_TICK: begin
                     prescale_in = prescale_ff + 1'b1;
                     vidx_in     = '0;
                     acc_in      = '0;
                  end
                  ACT_SEQ_STEP: begin
                     for (int i = 0; i < VOICE_COUNT; i++) begin
                        if (remaining_ff[i] == '0) begin
                           busy_in[i] = 1'b0;
                        end else begin
                           remaining_in[i] = remaining_ff[i] - 1'b1;
                        end
                     end
                  end
                  ACT_NOTE_ON: begin
                     step_in[note_voice]      = req_step;
                     remaining_in[note_voice] = req_dur;
                     phase_in[note_voice]     = '0;
                     busy_in[note_voice]      = 1'b1;
                  end
                  ACT_SET_WAVE: begin
                     if (req_voice < 2'(VOICE_COUNT)) begin
                        wave_in[req_voice[VOICE_IDX_W-1:0]] = req_wave;
                     end
                  end
                  ACT_STOP_VOICE: begin
                     if (req_voice < 2'(VOICE_COUNT)) begin
                        busy_in[req_voice[VOICE_IDX_W-1:0]] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_VOICE: begin
            if (busy_ff[vidx_ff]) begin
               phase_in[vidx_ff] = unit_phase;
               acc_in.sum        = acc_ff.sum + {{(SUM_W-SAMPLE_W){1'b0}}, unit_sample};
               acc_in.count      = acc_ff.count + 1'b1;
            end
            vidx_in = vidx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      duty_in      = duty_ff;
      sounding_in  = sounding_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_MIX && acc_ff.count != '0 && out_free) begin
         rsp_valid_in = 1'b1;
         duty_in      = average;
         sounding_in  = acc_ff.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICE_COUNT; i++) begin
            phase_ff[i]     <= '0;
            step_ff[i]      <= '0;
            wave_ff[i]      <= WAVE_SINE;
            remaining_ff[i] <= '0;
         end
         busy_ff      <= '0;
         prescale_ff  <= '0;
         vidx_ff      <= '0;
         acc_ff       <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         wave_ff      <= wave_in;
         remaining_ff <= remaining_in;
         busy_ff      <= busy_in;
         prescale_ff  <= prescale_in;
         vidx_ff      <= vidx_in;
         acc_ff       <= acc_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      duty_ff     <= duty_in;
      sounding_ff <= sounding_in;
   end

endmodule

>>> verif/three_voice_wavetable_synth_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for three_voice_wavetable_synth_top: a directed table, then random
// voice traffic under varying stalls, checked against a behavioral oscillator and mixer model
// depends on wts_pkg and the rtl of three_voice_wavetable_synth_top
module three_voice_wavetable_synth_top_tb;
   import wts_pkg::*;

   localparam logic [2:0] ACT_UNUSED_LO   = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI   = 3'd7;
   localparam logic [1:0] VOICE_NONE      = 2'd3;
   localparam int         ITEMS_PER_PHASE = 520;
   localparam int         HOLD_ITEM       = 250;
   localparam int         HOLD_CYCLES     = 400;
   localparam int         STALL_LIMIT     = 4000;
   localparam int         DRAIN_CYCLES    = 16;
   localparam int         MAX_REPORTS     = 10;
   localparam int         SEND_IDLE [3]   = '{29, 53, 0};
   localparam int         RECV_IDLE [3]   = '{53, 29, 0};

   localparam logic [6:0] SINE_QUARTER [0:64] = '{
        7'd0,   7'd3,   7'd6,   7'd9,  7'd12,  7'd16,  7'd19,  7'd22,  7'd25,  7'd28,
       7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,  7'd49,  7'd51,  7'd54,  7'd57,
       7'd60,  7'd63,  7'd65,  7'd68,  7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,
       7'd85,  7'd88,  7'd90,  7'd92,  7'd94,  7'd96,  7'd98, 7'd100, 7'd102, 7'd104,
      7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116, 7'd117, 7'd118,
      7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126,
      7'd126, 7'd127, 7'd127, 7'd127, 7'd127
   };

   typedef struct packed {
      logic [2:0] act;
      logic [8:0] step;
      logic [7:0] dur;
      logic [1:0] vi;
      wave_type   ws;
   } synth_req_type;

   typedef struct packed {
      logic [7:0] duty;
      logic [1:0] voices;
   } mix_type;

   typedef struct packed {
      synth_req_type req;
      logic          typed;
      logic          has_rsp;
      mix_type       mix;
   } dir_row_type;

   localparam dir_row_type DIRECTED [25] = '{
      '{'{ACT_SAMPLE_TICK, 9'd0,   8'd0,   2'd0,       WAVE_SINE},     1'b1, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_NOTE_ON,     9'd511, 8'd0,   2'd0,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SET_WAVE,    9'd0,   8'd0,   2'd0,       WAVE_SQUARE},   1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SET_WAVE,    9'd0,   8'd0,   VOICE_NONE, WAVE_SAWTOOTH}, 1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_UNUSED_LO,   9'd511, 8'd255, VOICE_NONE, WAVE_SAWTOOTH}, 1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_UNUSED_HI,   9'd0,   8'd0,   2'd0,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_STOP_VOICE,  9'd0,   8'd0,   VOICE_NONE, WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SAMPLE_TICK, 9'd511, 8'd255, VOICE_NONE, WAVE_SAWTOOTH}, 1'b1, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SAMPLE_TICK, 9'd0,   8'd0,   2'd0,       WAVE_SINE},     1'b1, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SAMPLE_TICK, 9'd511, 8'd255, VOICE_NONE, WAVE_SAWTOOTH}, 1'b1, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SAMPLE_TICK, 9'd0,   8'd0,   2'd0,       WAVE_SINE},     1'b1, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SAMPLE_TICK, 9'd511, 8'd255, VOICE_NONE, WAVE_SAWTOOTH}, 1'b1, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SAMPLE_TICK, 9'd0,   8'd0,   2'd0,       WAVE_SINE},     1'b1, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SAMPLE_TICK, 9'd511, 8'd255, VOICE_NONE, WAVE_SAWTOOTH}, 1'b1, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SAMPLE_TICK, 9'd0,   8'd0,   2'd0,       WAVE_SINE},     1'b1, 1'b1, '{8'd255, 2'd1}},
      '{'{ACT_SEQ_STEP,    9'd0,   8'd0,   2'd0,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_NOTE_ON,     9'd0,   8'd255, 2'd0,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_NOTE_ON,     9'd1,   8'd1,   2'd0,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_NOTE_ON,     9'd256, 8'd2,   2'd0,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_NOTE_ON,     9'd128, 8'd3,   2'd0,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SET_WAVE,    9'd0,   8'd0,   2'd1,       WAVE_TRIANGLE}, 1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SET_WAVE,    9'd0,   8'd0,   2'd2,       WAVE_SAWTOOTH}, 1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_STOP_VOICE,  9'd0,   8'd0,   2'd1,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SEQ_STEP,    9'd0,   8'd0,   2'd0,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}},
      '{'{ACT_SAMPLE_TICK, 9'd0,   8'd0,   2'd0,       WAVE_SINE},     1'b0, 1'b0, '{8'd0,   2'd0}}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // phase_step[8:0], note_duration[16:9], voice_index[18:17],
                              // wave_select[20:19], zero fill
   logic [2:0]  req_tuser;    // action[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // duty[7:0], voices_sounding[9:8], zero fill

   // model state
   logic [8:0] osc_phase [VOICE_COUNT] = '{default: '0};
   logic [8:0] osc_step  [VOICE_COUNT] = '{default: '0};
   wave_type   osc_wave  [VOICE_COUNT] = '{default: WAVE_SINE};
   logic [7:0] osc_left  [VOICE_COUNT] = '{default: '0};
   logic [2:0] osc_on    = '0;
   logic [2:0] tick_div  = '0;

   mix_type expected_mix [$];
   mix_type seen_mix;
   mix_type want_mix;
   int      mismatches    = 0;
   int      quiet_cycles  = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_rsp_req  = 1'b0;
   int      hold_left     = 0;

   three_voice_wavetable_synth_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] shape_sample(input wave_type w, input logic [8:0] p);
      logic [7:0] idx;
      logic [6:0] k;
      case (w)
         WAVE_SINE: begin
            idx = p[8:1];
            k   = idx[6:0];
            if (k > 7'd64) begin
               k = 7'd0 - k;
            end
            shape_sample = idx[7] ? 8'd127 - {1'b0, SINE_QUARTER[k]}
                                  : 8'd128 + {1'b0, SINE_QUARTER[k]};
         end
         WAVE_TRIANGLE: shape_sample = p[8] ? 8'd255 - p[7:0] : p[7:0];
         WAVE_SQUARE:   shape_sample = p[8] ? 8'hFF : 8'h00;
         default:       shape_sample = p[8:1];
      endcase
   endfunction

   task automatic predict_mix(input synth_req_type it, output bit got, output mix_type m);
      int         sum;
      int         cnt;
      int         v;
      logic [1:0] slot;
      got = 1'b0;
      m   = '0;
      sum = 0;
      cnt = 0;
      case (it.act)
         ACT_SAMPLE_TICK: begin
            if (tick_div == 3'd0) begin
               for (v = 0; v < VOICE_COUNT; v++) begin
                  if (osc_on[v]) begin
                     cnt++;
                     osc_phase[v] = osc_phase[v] + osc_step[v];
                     sum += shape_sample(osc_wave[v], osc_phase[v]);
                  end
               end
               if (cnt != 0) begin
                  got      = 1'b1;
                  m.duty   = 8'(sum / cnt);
                  m.voices = 2'(cnt);
               end
            end
            tick_div = tick_div + 3'd1;
         end
         ACT_SEQ_STEP: begin
            for (v = 0; v < VOICE_COUNT; v++) begin
               if (osc_left[v] == 8'd0) begin
                  osc_on[v] = 1'b0;
               end else begin
                  osc_left[v] = osc_left[v] - 8'd1;
               end
            end
         end
         ACT_NOTE_ON: begin
            slot = !osc_on[0] ? 2'd0 : (!osc_on[1] ? 2'd1 : 2'd2);
            osc_step[slot]  = it.step;
            osc_left[slot]  = it.dur;
            osc_phase[slot] = '0;
            osc_on[slot]    = 1'b1;
         end
         ACT_SET_WAVE: begin
            if (it.vi != VOICE_NONE) begin
               osc_wave[it.vi] = it.ws;
            end
         end
         ACT_STOP_VOICE: begin
            if (it.vi != VOICE_NONE) begin
               osc_on[it.vi] = 1'b0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input synth_req_type it, output bit got, output mix_type m);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.act;
      req_tdata  <= {3'b000, it.ws, it.vi, it.dur, it.step};
      do @(posedge clock); while (!req_tready);
      predict_mix(it, got, m);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_mix.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed voice traffic, a few ignored items as noise
   task automatic random_request(output synth_req_type it, output bit noise);
      int r;
      r        = $urandom_range(0, 99);
      noise    = 1'b0;
      it.step  = 9'($urandom_range(0, 511));
      it.dur   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 12));
      it.vi    = 2'($urandom_range(0, 2));
      it.ws    = wave_type'($urandom_range(0, 3));
      if (r < 58) begin
         it.act = ACT_SAMPLE_TICK;
      end else if (r < 70) begin
         it.act = ACT_NOTE_ON;
      end else if (r < 78) begin
         it.act = ACT_SEQ_STEP;
      end else if (r < 88) begin
         it.act = ACT_SET_WAVE;
      end else if (r < 93) begin
         it.act = ACT_STOP_VOICE;
      end else begin
         noise = 1'b1;
         if (r < 97) begin
            it.act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            it.vi  = 2'($urandom_range(0, 3));
         end else begin
            it.act = (r < 99) ? ACT_SET_WAVE : ACT_STOP_VOICE;
            it.vi  = VOICE_NONE;
         end
      end
   endtask

   // receiver with random stalls and one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_mix.duty   = rsp_tdata[7:0];
         seen_mix.voices = rsp_tdata[9:8];
         if (expected_mix.size() == 0) begin
            if (mismatches < MAX_REPORTS) begin
               $display("unexpected transfer: duty %0d voices %0d",
                        seen_mix.duty, seen_mix.voices);
            end
            mismatches++;
         end else begin
            want_mix = expected_mix.pop_front();
            if (seen_mix.duty !== want_mix.duty || seen_mix.voices !== want_mix.voices) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("mismatch: duty exp %0d got %0d, voices exp %0d got %0d",
                           want_mix.duty, seen_mix.duty, want_mix.voices, seen_mix.voices);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int            i;
      int            ph;
      int            counted;
      bit            got;
      bit            noise;
      bit            hold_done;
      mix_type       m;
      synth_req_type it;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      hold_done  = 1'b0;
      send_idle_pct = SEND_IDLE[0];
      recv_idle_pct = RECV_IDLE[0];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < 25; i++) begin
         send_item(DIRECTED[i].req, got, m);
         if (DIRECTED[i].typed) begin
            if (DIRECTED[i].has_rsp) begin
               expected_mix.push_back(DIRECTED[i].mix);
            end
         end else if (got) begin
            expected_mix.push_back(m);
         end
      end

      for (ph = 0; ph < 3; ph++) begin
         if (ph != 0) begin
            pause_until_drained();
         end
         send_idle_pct = SEND_IDLE[ph];
         recv_idle_pct = RECV_IDLE[ph];
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            if (ph == 0 && !hold_done && counted >= HOLD_ITEM) begin
               // long note so results back up while the receiver holds off
               it = '{ACT_NOTE_ON, 9'd37, 8'd255, 2'd0, WAVE_SINE};
               send_item(it, got, m);
               if (got) begin
                  expected_mix.push_back(m);
               end
               hold_rsp_req = 1'b1;
               hold_done    = 1'b1;
            end
            random_request(it, noise);
            send_item(it, got, m);
            if (got) begin
               expected_mix.push_back(m);
            end
            if (!noise) begin
               counted++;
            end
         end
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_mix.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/wts_pkg.sv
rtl/wts_voice_unit.sv
rtl/wts_mix_divide.sv
rtl/three_voice_wavetable_synth_top.sv
verif/three_voice_wavetable_synth_top_tb.sv
